FILE: design/u8u16_pkg.sv
package u8u16_pkg;

    localparam int Q_DEPTH = 4;

    localparam int BYTE_W  = 8;
    localparam int UNIT_W  = 16;
    localparam int CP_W    = 21;
    localparam int PAIR_W  = 20;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_BAD_LEAD = 3'd1,
        ST_BAD_CONT = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_SURR     = 3'd4,
        ST_BIG      = 3'd5
    } status_t;

    localparam logic [5:0] HI_SURR_TAG = 6'b110110;
    localparam logic [5:0] LO_SURR_TAG = 6'b110111;

    // One queued job for the output side: a single unit or a surrogate pair.
    // For a pair the payload holds the code point less 0x10000.
    typedef struct packed {
        logic              pair;
        logic [PAIR_W-1:0] payload;
        status_t           status;
        logic              eos;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } push_t;

endpackage

FILE: design/u8u16_front.sv
module u8u16_front
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  logic [u8u16_pkg::BYTE_W-1:0] in_byte,
    input  logic                       end_of_string,
    output u8u16_pkg::push_t           push_out
);
    import u8u16_pkg::*;

    logic [CP_W-1:0] acc_reg, acc_next;
    logic [1:0]      rem_reg, rem_next;
    logic            disc_reg, disc_next;

    logic [CP_W-1:0] cp;
    logic [CP_W-1:0] cp_off;
    logic            emit_cp;
    logic            err;
    status_t         err_st;

    always_comb
    begin
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        disc_next = disc_reg;
        cp        = '0;
        emit_cp   = 1'b0;
        err       = 1'b0;
        err_st    = ST_OK;

        if (disc_reg)
        begin
            if (end_of_string)
            begin
                disc_next = 1'b0;
            end
        end
        else if (rem_reg == 2'd0)
        begin
            priority if (in_byte[7] == 1'b0)
            begin
                emit_cp = 1'b1;
                cp      = {{(CP_W-BYTE_W){1'b0}}, in_byte};
            end
            else if (in_byte[7:6] == 2'b10)
            begin
                err    = 1'b1;
                err_st = ST_BAD_LEAD;
            end
            else if (in_byte[7:5] == 3'b110)
            begin
                acc_next = {{(CP_W-5){1'b0}}, in_byte[4:0]};
                rem_next = 2'd1;
            end
            else if (in_byte[7:4] == 4'b1110)
            begin
                acc_next = {{(CP_W-4){1'b0}}, in_byte[3:0]};
                rem_next = 2'd2;
            end
            else if (in_byte[7:3] == 5'b11110)
            begin
                acc_next = {{(CP_W-3){1'b0}}, in_byte[2:0]};
                rem_next = 2'd3;
            end
            else
            begin
                err    = 1'b1;
                err_st = ST_BAD_LEAD;
            end
            // A lead byte that opens a sequence cannot also close the string.
            if (!err && !emit_cp && end_of_string)
            begin
                err    = 1'b1;
                err_st = ST_TRUNC;
            end
        end
        else
        begin
            if (in_byte[7:6] != 2'b10)
            begin
                err    = 1'b1;
                err_st = ST_BAD_CONT;
            end
            else
            begin
                cp       = {acc_reg[CP_W-7:0], in_byte[5:0]};
                acc_next = cp;
                rem_next = rem_reg - 2'd1;
                if (rem_reg == 2'd1)
                begin
                    emit_cp = 1'b1;
                end
                else if (end_of_string)
                begin
                    err    = 1'b1;
                    err_st = ST_TRUNC;
                end
            end
        end

        if (emit_cp)
        begin
            acc_next = '0;
            rem_next = 2'd0;
            if (cp >= CP_W'(24'hD800) && cp <= CP_W'(24'hDFFF))
            begin
                err    = 1'b1;
                err_st = ST_SURR;
            end
            else if (cp > CP_W'(24'h10FFFF))
            begin
                err    = 1'b1;
                err_st = ST_BIG;
            end
        end

        if (err)
        begin
            acc_next  = '0;
            rem_next  = 2'd0;
            disc_next = !end_of_string;
        end
    end

    assign cp_off = cp - CP_W'(24'h10000);

    always_comb
    begin
        push_out.push         = accept && (emit_cp || err);
        push_out.entry.eos    = end_of_string;
        push_out.entry.status = err ? err_st : ST_OK;
        if (err)
        begin
            push_out.entry.pair    = 1'b0;
            push_out.entry.payload = '0;
        end
        else if (cp[CP_W-1:UNIT_W] != '0)
        begin
            push_out.entry.pair    = 1'b1;
            push_out.entry.payload = cp_off[PAIR_W-1:0];
        end
        else
        begin
            push_out.entry.pair    = 1'b0;
            push_out.entry.payload = {{(PAIR_W-UNIT_W){1'b0}}, cp[UNIT_W-1:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            rem_reg  <= 2'd0;
            disc_reg <= 1'b0;
        end
        else if (accept)
        begin
            acc_reg  <= acc_next;
            rem_reg  <= rem_next;
            disc_reg <= disc_next;
        end
    end

endmodule

FILE: design/u8u16_queue.sv
module u8u16_queue
#(
    parameter int QueueDepth = u8u16_pkg::Q_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  u8u16_pkg::push_t    push_in,
    input  logic                pop,
    output u8u16_pkg::entry_t   head,
    output logic                empty,
    output logic                full
);
    import u8u16_pkg::*;

    localparam int PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
    localparam int CntW = $clog2(QueueDepth + 1);
    localparam logic [PtrW-1:0] LastIdx = PtrW'(QueueDepth - 1);

    entry_t          mem [QueueDepth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CntW'(QueueDepth));
    assign do_push = push_in.push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LastIdx) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LastIdx) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CntW'(do_push) - CntW'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_in.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: design/u8u16_back.sv
module u8u16_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  u8u16_pkg::entry_t             head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          unit_valid,
    input  logic                          unit_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]  code_unit,
    output u8u16_pkg::status_t            status,
    output logic                          run_last,
    output logic                          string_done
);
    import u8u16_pkg::*;

    logic              valid_reg, valid_next;
    logic              half_reg, half_next;
    logic [UNIT_W-1:0] unit_reg, unit_next;
    status_t           status_reg, status_next;
    logic              last_reg, last_next;
    logic              done_reg, done_next;
    logic              load;

    // The output register takes a new result whenever it is empty or being drained.
    assign load = !valid_reg || unit_ready;

    always_comb
    begin
        valid_next  = valid_reg;
        half_next   = half_reg;
        unit_next   = unit_reg;
        status_next = status_reg;
        last_next   = last_reg;
        done_next   = done_reg;
        pop         = 1'b0;
        if (load)
        begin
            valid_next = !empty;
            if (!empty)
            begin
                status_next = head.status;
                if (head.pair && !half_reg)
                begin
                    unit_next = {HI_SURR_TAG, head.payload[PAIR_W-1:10]};
                    last_next = 1'b0;
                    done_next = 1'b0;
                    half_next = 1'b1;
                end
                else if (head.pair)
                begin
                    unit_next = {LO_SURR_TAG, head.payload[9:0]};
                    last_next = 1'b1;
                    done_next = head.eos;
                    half_next = 1'b0;
                    pop       = 1'b1;
                end
                else
                begin
                    unit_next = head.payload[UNIT_W-1:0];
                    last_next = 1'b1;
                    done_next = head.eos;
                    pop       = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            half_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            half_reg  <= half_next;
        end
    end

    always_ff @(posedge clk)
    begin
        unit_reg   <= unit_next;
        status_reg <= status_next;
        last_reg   <= last_next;
        done_reg   <= done_next;
    end

    assign unit_valid  = valid_reg;
    assign code_unit   = unit_reg;
    assign status      = status_reg;
    assign run_last    = last_reg;
    assign string_done = done_reg;

endmodule

FILE: design/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder. One byte is taken per clock while the internal
// queue has room; a byte that completes a code point or hits an error places one
// job in a QueueDepth-entry queue, and the output register drains it, one UTF-16
// unit per clock while unit_ready holds, so a surrogate pair gives two units.
// Sustained input rate is one byte per cycle, limited only by the output side when
// pairs or a stalled consumer fill the queue. A byte's first result is written
// to the queue and then to the output register. After an error the block keeps
// accepting bytes but yields nothing up to and including the end_of_string byte.
module utf8_to_utf16_transcoder
#(
    parameter int QueueDepth = u8u16_pkg::Q_DEPTH
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           byte_valid,
    output logic                           byte_ready,
    input  logic [u8u16_pkg::BYTE_W-1:0]   in_byte,
    input  logic                           end_of_string,
    output logic                           unit_valid,
    input  logic                           unit_ready,
    output logic [u8u16_pkg::UNIT_W-1:0]   code_unit,
    output logic [2:0]                     status,
    output logic                           run_last,
    output logic                           string_done
);
    import u8u16_pkg::*;

    push_t   push;
    entry_t  head;
    logic    empty;
    logic    full;
    logic    pop;
    logic    accept;
    status_t status_int;

    assign byte_ready = !full;
    assign accept     = byte_valid && byte_ready;

    u8u16_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .push_out      (push)
    );

    u8u16_queue #(.QueueDepth(QueueDepth)) u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push_in (push),
        .pop     (pop),
        .head    (head),
        .empty   (empty),
        .full    (full)
    );

    u8u16_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .empty       (empty),
        .pop         (pop),
        .unit_valid  (unit_valid),
        .unit_ready  (unit_ready),
        .code_unit   (code_unit),
        .status      (status_int),
        .run_last    (run_last),
        .string_done (string_done)
    );

    assign status = status_int;

endmodule

FILE: design/u8u16_props.sv
module u8u16_props
(
    input logic        clk,
    input logic        rst_n,
    input logic        unit_valid,
    input logic        unit_ready,
    input logic [15:0] code_unit,
    input logic [2:0]  status,
    input logic        run_last,
    input logic        string_done
);
    import u8u16_pkg::*;

    // A stalled result must hold still.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !unit_ready |=> unit_valid && $stable(code_unit)
            && $stable(status) && $stable(run_last) && $stable(string_done))
        else $error("result changed while stalled");

    // Error results carry a zero unit and close the run of their item.
    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && status != ST_OK |-> code_unit == '0 && run_last)
        else $error("malformed error result");

    // Only a high surrogate can be a non-final result of an item.
    a_first_half: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && !run_last |-> status == ST_OK && !string_done
            && code_unit[15:10] == HI_SURR_TAG)
        else $error("non-final result is not a high surrogate");

    // A taken high surrogate is followed at once by its low half.
    a_second_half: assert property (@(posedge clk) disable iff (!rst_n)
        unit_valid && unit_ready && !run_last |=> unit_valid && run_last
            && status == ST_OK && code_unit[15:10] == LO_SURR_TAG)
        else $error("low surrogate missing after high surrogate");

endmodule

bind utf8_to_utf16_transcoder u8u16_props u_props (.*);
